>>> rtl/mhl_pkg.sv
// Shared types and constants for the MRU history list unit.
// No dependencies; compiled first.
package mhl_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam logic [5:0] MAX_ENTRIES_RESET = 6'd20;

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef struct packed {
        func_t       func;
        logic [4:0]  index;
        logic [7:0]  driver_id;
        logic [7:0]  space;
        logic [11:0] channel_index;
        logic [15:0] service_id;
        logic [9:0]  service_number;
    } req_t;

    typedef struct packed {
        logic [7:0]  driver_id;
        logic [7:0]  space;
        logic [11:0] channel_index;
        logic [15:0] service_id;
        logic [9:0]  service_number;
    } entry_t;

    typedef struct packed {
        logic        entry_valid;
        logic [7:0]  out_driver;
        logic [7:0]  out_space;
        logic [11:0] out_channel;
        logic [15:0] out_service_id;
        logic [9:0]  out_service;
        logic        was_present;
        logic [4:0]  hit_position;
        logic        evicted;
        logic [5:0]  entry_count;
    } rsp_t;

endpackage

>>> rtl/mhl_stream_if.sv
// Valid/ready stream interface carrying one item of type T.
// No dependencies; the payload type is set where it is instantiated.
interface mhl_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/mru_history_list_unit.sv
// MRU history list unit: move-to-front list of keyed entries.
// Depends on mhl_pkg, mhl_stream_if and mhl_entry_store.
//
// Usage:
//   req  : valid/ready request items (add, read, clear, no-op).
//   rsp  : valid/ready result items, exactly one per request.
//   cfg_wr_en/cfg_wr_data : writes max_entries; write only while idle.
// Sequence per request (after it is accepted):
//   add   : the scan stops at the hit index, or at the entry count on a miss.
//           One memory read and one write per cycle: the scan compares entry
//           k while moving entry k-1 down into slot k.
//   read  : address, registered memory read, result.
//   clear, no-op : straight to the result.
// One request is in work at a time: req.ready returns with rsp.valid. A finished
// result sits in the output register until rsp.ready, and the next request may
// be accepted meanwhile; a second result waits in the sequencer until the output
// register frees.
// Reset: list empty (count 0), max_entries = 20, no result pending. The entry
// memory is not cleared; data read from positions at or above the count is never used.
module mru_history_list_unit
    import mhl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    mhl_stream_if.sink   req,
    mhl_stream_if.source rsp,
    input  logic       cfg_wr_en,
    input  logic [5:0] cfg_wr_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int TW = (CW + 1 > 6) ? CW + 1 : 6;
    localparam logic [TW-1:0] DEPTH_T = TW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_START,
        S_ADD_SCAN,
        S_READ_RD,
        S_READ_DATA,
        S_EMIT
    } state_t;

    state_t        state_reg, state_next;
    req_t          item_reg, item_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    entry_t        prev_reg, prev_next;
    rsp_t          res_reg, res_next;
    logic          out_valid_reg, out_valid_next;
    rsp_t          out_data_reg, out_data_next;
    logic [5:0]    max_entries_reg, max_entries_next;

    logic          st_rd_en;
    logic [AW-1:0] st_rd_addr;
    entry_t        st_rd_data;
    logic          st_wr_en;
    logic [AW-1:0] st_wr_addr;
    entry_t        st_wr_data;
    logic          st_key_hit;

    entry_t        new_entry;
    logic [TW-1:0] limit;
    logic [TW-1:0] total;
    logic [TW-1:0] ptr_inc;
    logic          evict;

    assign new_entry.driver_id      = item_reg.driver_id;
    assign new_entry.space          = item_reg.space;
    assign new_entry.channel_index  = item_reg.channel_index;
    assign new_entry.service_id     = item_reg.service_id;
    assign new_entry.service_number = item_reg.service_number;

    assign limit   = (TW'(max_entries_reg) > DEPTH_T) ? DEPTH_T : TW'(max_entries_reg);
    assign ptr_inc = TW'(ptr_reg) + TW'(1);

    mhl_entry_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .key     (new_entry),
        .key_hit (st_key_hit)
    );

    always_comb
    begin
        state_next       = state_reg;
        item_next        = item_reg;
        count_next       = count_reg;
        ptr_next         = ptr_reg;
        prev_next        = prev_reg;
        res_next         = res_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_data_next    = out_data_reg;
        max_entries_next = cfg_wr_en ? cfg_wr_data : max_entries_reg;
        st_rd_en         = 1'b0;
        st_rd_addr       = '0;
        st_wr_en         = 1'b0;
        st_wr_addr       = '0;
        st_wr_data       = prev_reg;
        total            = '0;
        evict            = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    item_next = req.data;
                    res_next  = '0;
                    case (req.data.func)
                        FUNC_ADD:   state_next = S_ADD_START;
                        FUNC_READ:  state_next = S_READ_RD;
                        FUNC_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            res_next.entry_count = 6'(count_reg);
                            state_next           = S_EMIT;
                        end
                    endcase
                end
            end

            S_ADD_START:
            begin
                st_rd_en   = 1'b1;
                ptr_next   = '0;
                state_next = S_ADD_SCAN;
            end

            S_ADD_SCAN:
            begin
                st_rd_en   = (ptr_inc < DEPTH_T);
                st_rd_addr = AW'(ptr_inc);
                if (ptr_reg == count_reg)
                begin
                    // miss: old last entry lands at count, or falls off a full list
                    st_wr_en   = (TW'(count_reg) < DEPTH_T);
                    st_wr_addr = AW'(count_reg);
                    st_wr_data = (count_reg == '0) ? new_entry : prev_reg;
                    total      = TW'(count_reg) + TW'(1);
                    evict      = (total > limit);
                    if (evict)
                    begin
                        total = total - TW'(1);
                    end
                    if (total > DEPTH_T)
                    begin
                        total = DEPTH_T;
                    end
                    count_next           = CW'(total);
                    res_next.evicted     = evict;
                    res_next.entry_count = 6'(total);
                    state_next           = S_EMIT;
                end
                else if (st_key_hit)
                begin
                    res_next.was_present  = 1'b1;
                    res_next.hit_position = 5'(ptr_reg);
                    if (ptr_reg != '0)
                    begin
                        st_wr_en   = 1'b1;
                        st_wr_addr = AW'(ptr_reg);
                        st_wr_data = prev_reg;
                        evict      = (TW'(count_reg) > limit);
                        if (evict)
                        begin
                            count_next = count_reg - CW'(1);
                        end
                        res_next.evicted     = evict;
                        res_next.entry_count = evict ? 6'(count_reg - CW'(1))
                                                     : 6'(count_reg);
                    end
                    else
                    begin
                        res_next.entry_count = 6'(count_reg);
                    end
                    state_next = S_EMIT;
                end
                else
                begin
                    st_wr_en   = 1'b1;
                    st_wr_addr = AW'(ptr_reg);
                    st_wr_data = (ptr_reg == '0) ? new_entry : prev_reg;
                    prev_next  = st_rd_data;
                    ptr_next   = ptr_reg + CW'(1);
                end
            end

            S_READ_RD:
            begin
                st_rd_en   = (TW'(item_reg.index) < DEPTH_T);
                st_rd_addr = AW'(item_reg.index);
                state_next = S_READ_DATA;
            end

            S_READ_DATA:
            begin
                if (TW'(item_reg.index) < TW'(count_reg))
                begin
                    res_next.entry_valid    = 1'b1;
                    res_next.out_driver     = st_rd_data.driver_id;
                    res_next.out_space      = st_rd_data.space;
                    res_next.out_channel    = st_rd_data.channel_index;
                    res_next.out_service_id = st_rd_data.service_id;
                    res_next.out_service    = st_rd_data.service_number;
                end
                res_next.entry_count = 6'(count_reg);
                state_next           = S_EMIT;
            end

            S_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            ptr_reg         <= '0;
            out_valid_reg   <= 1'b0;
            max_entries_reg <= MAX_ENTRIES_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            item_reg        <= item_next;
            count_reg       <= count_next;
            ptr_reg         <= ptr_next;
            prev_reg        <= prev_next;
            res_reg         <= res_next;
            out_valid_reg   <= out_valid_next;
            out_data_reg    <= out_data_next;
            max_entries_reg <= max_entries_next;
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        TW'(count_reg) <= DEPTH_T)
        else $error("entry count above depth");

    a_scan_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD_SCAN) |-> (ptr_reg <= count_reg))
        else $error("scan pointer past entry count");

    a_write_scan_only: assert property (@(posedge clk) disable iff (!rst_n)
        st_wr_en |-> (state_reg == S_ADD_SCAN))
        else $error("memory write outside add scan");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("second item taken while one is in work");

    a_valid_read_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.entry_valid) |-> (rsp.data.entry_count != 6'd0))
        else $error("valid read from an empty list");

endmodule

>>> rtl/mhl_entry_store.sv
// Entry memory of the MRU list: one write port, one registered read port,
// and the key comparator on the read data. Depends on mhl_pkg.
module mhl_entry_store
    import mhl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  entry_t        key,
    output logic          key_hit
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

    // payload (service_number) is not part of the key
    assign key_hit = (rd_data_reg.driver_id     == key.driver_id)     &&
                     (rd_data_reg.space         == key.space)         &&
                     (rd_data_reg.channel_index == key.channel_index) &&
                     (rd_data_reg.service_id    == key.service_id);

endmodule

>>> tb/tb.sv
// Self-checking bench for mru_history_list_unit: directed table, then random phases
// at several list limits, with a shadow move-to-front list predicting all but the fixed rows' results.
// Depends on rtl/mhl_pkg.sv, rtl/mhl_stream_if.sv and the unit's RTL.
module tb
    import mhl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH = DEPTH_DEFAULT;
    localparam int KEY_POOL = 48;
    localparam int PHASE_ITEMS = 220;
    localparam int SETTLE = 40;

    typedef struct {
        bit         cfg;
        logic [5:0] cfg_val;
        req_t       r;
        bit         fixed;
        rsp_t       want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [5:0] cfg_wr_data;

    mhl_stream_if #(.T(req_t)) req_if ();
    mhl_stream_if #(.T(rsp_t)) rsp_if ();

    mru_history_list_unit u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_if),
        .rsp         (rsp_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    entry_t      shadow_list [LIST_DEPTH];
    int unsigned shadow_count;
    logic [5:0]  shadow_limit;
    rsp_t        mru_answers [$];
    entry_t      key_pool [KEY_POOL];
    dir_row_t    dir_rows [$];
    int unsigned burst_left;
    int unsigned mismatches;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("tb: done, errors");
        $finish;
    end

    // move-to-front list: updates the shadow state and returns the answer
    function automatic rsp_t apply_to_shadow_list(input req_t r);
        rsp_t        o;
        entry_t      e;
        int unsigned hit;
        int unsigned moves;
        int unsigned total;
        int unsigned lim;
        int unsigned i;
        o = '0;
        case (r.func)
            FUNC_ADD:
            begin
                e.driver_id      = r.driver_id;
                e.space          = r.space;
                e.channel_index  = r.channel_index;
                e.service_id     = r.service_id;
                e.service_number = r.service_number;
                lim = (int'(shadow_limit) > LIST_DEPTH) ? LIST_DEPTH : int'(shadow_limit);
                hit = shadow_count;
                for (i = 0; i < shadow_count; i++)
                begin
                    if (hit == shadow_count &&
                        shadow_list[i].driver_id == e.driver_id &&
                        shadow_list[i].space == e.space &&
                        shadow_list[i].channel_index == e.channel_index &&
                        shadow_list[i].service_id == e.service_id)
                        hit = i;
                end
                if (hit < shadow_count)
                begin
                    o.was_present  = 1'b1;
                    o.hit_position = hit[4:0];
                    if (hit == 0)
                    begin
                        o.entry_count = shadow_count[5:0];
                        return o;
                    end
                    moves = hit;
                    total = shadow_count;
                end
                else
                begin
                    moves = (shadow_count < LIST_DEPTH) ? shadow_count : LIST_DEPTH - 1;
                    total = shadow_count + 1;
                end
                for (i = moves; i > 0; i--)
                    shadow_list[i] = shadow_list[i - 1];
                shadow_list[0] = e;
                if (total > lim)
                begin
                    total--;
                    o.evicted = 1'b1;
                end
                if (total > LIST_DEPTH)
                    total = LIST_DEPTH;
                shadow_count  = total;
                o.entry_count = total[5:0];
            end
            FUNC_READ:
            begin
                if (r.index < shadow_count)
                begin
                    o.entry_valid    = 1'b1;
                    o.out_driver     = shadow_list[r.index].driver_id;
                    o.out_space      = shadow_list[r.index].space;
                    o.out_channel    = shadow_list[r.index].channel_index;
                    o.out_service_id = shadow_list[r.index].service_id;
                    o.out_service    = shadow_list[r.index].service_number;
                end
                o.entry_count = shadow_count[5:0];
            end
            FUNC_CLEAR:
                shadow_count = 0;
            default:
                o.entry_count = shadow_count[5:0];
        endcase
        return o;
    endfunction

    function automatic rsp_t bare_answer(input bit present, input logic [4:0] pos,
                                         input bit evict, input logic [5:0] cnt);
        rsp_t o;
        o = '0;
        o.was_present  = present;
        o.hit_position = pos;
        o.evicted      = evict;
        o.entry_count  = cnt;
        return o;
    endfunction

    function automatic dir_row_t item_row(input func_t f, input logic [4:0] idx,
                                          input entry_t e);
        dir_row_t row;
        row = '{default: '0};
        row.r.func           = f;
        row.r.index          = idx;
        row.r.driver_id      = e.driver_id;
        row.r.space          = e.space;
        row.r.channel_index  = e.channel_index;
        row.r.service_id     = e.service_id;
        row.r.service_number = e.service_number;
        return row;
    endfunction

    function automatic dir_row_t fixed_row(input func_t f, input logic [4:0] idx,
                                           input entry_t e, input rsp_t want);
        dir_row_t row;
        row = item_row(f, idx, e);
        row.fixed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic dir_row_t cfg_row(input logic [5:0] v);
        dir_row_t row;
        row = '{default: '0};
        row.cfg     = 1'b1;
        row.cfg_val = v;
        return row;
    endfunction

    function automatic req_t next_random_req();
        req_t        r;
        logic [63:0] raw;
        int unsigned pick;
        int unsigned k;
        raw  = {$urandom, $urandom};
        r    = raw[$bits(req_t)-1:0];
        pick = $urandom_range(0, 199);
        if (pick < 110)
        begin
            r.func = FUNC_ADD;
            if ($urandom_range(0, 9) < 7)
            begin
                k = $urandom_range(0, KEY_POOL - 1);
                r.driver_id     = key_pool[k].driver_id;
                r.space         = key_pool[k].space;
                r.channel_index = key_pool[k].channel_index;
                r.service_id    = key_pool[k].service_id;
            end
        end
        else if (pick < 170)
        begin
            r.func = FUNC_READ;
            if (shadow_count != 0 && $urandom_range(0, 3) != 0)
                r.index = 5'($urandom_range(0, shadow_count - 1));
        end
        else if (pick < 173)
            r.func = FUNC_CLEAR;
        else
            r.func = FUNC_NOP;
        return r;
    endfunction

    task automatic refresh_key_pool();
        logic [63:0] raw;
        foreach (key_pool[i])
        begin
            raw = {$urandom, $urandom};
            key_pool[i] = raw[$bits(entry_t)-1:0];
            // odd slots differ from their neighbor in one key field only
            if (i % 2 == 1)
            begin
                key_pool[i] = key_pool[i - 1];
                case ($urandom_range(0, 3))
                    0: key_pool[i].driver_id     = raw[7:0];
                    1: key_pool[i].space         = raw[15:8];
                    2: key_pool[i].channel_index = raw[27:16];
                    default: key_pool[i].service_id = raw[43:28];
                endcase
            end
        end
    endtask

    task automatic flag(input string what, input int unsigned got, input int unsigned want);
        mismatches++;
        $display("tb: %0t mismatch %s: got %0h want %0h", $time, what, got, want);
    endtask

    task automatic check_answer(input rsp_t got, input rsp_t want);
        if (got.entry_valid !== want.entry_valid)
            flag("entry_valid", got.entry_valid, want.entry_valid);
        if (got.out_driver !== want.out_driver)
            flag("out_driver", got.out_driver, want.out_driver);
        if (got.out_space !== want.out_space)
            flag("out_space", got.out_space, want.out_space);
        if (got.out_channel !== want.out_channel)
            flag("out_channel", got.out_channel, want.out_channel);
        if (got.out_service_id !== want.out_service_id)
            flag("out_service_id", got.out_service_id, want.out_service_id);
        if (got.out_service !== want.out_service)
            flag("out_service", got.out_service, want.out_service);
        if (got.was_present !== want.was_present)
            flag("was_present", got.was_present, want.was_present);
        if (got.hit_position !== want.hit_position)
            flag("hit_position", got.hit_position, want.hit_position);
        if (got.evicted !== want.evicted)
            flag("evicted", got.evicted, want.evicted);
        if (got.entry_count !== want.entry_count)
            flag("entry_count", got.entry_count, want.entry_count);
    endtask

    // entered and left at a falling edge
    task automatic send_item(input req_t r, input bit fixed, input rsp_t want);
        rsp_t ans;
        if (burst_left == 0)
        begin
            req_if.valid = 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12))
                @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        req_if.data  = r;
        req_if.valid = 1'b1;
        do
            @(posedge clk);
        while (!req_if.ready);
        ans = apply_to_shadow_list(r);
        mru_answers.push_back(fixed ? want : ans);
        @(negedge clk);
    endtask

    task automatic write_limit(input logic [5:0] v);
        req_if.valid = 1'b0;
        burst_left   = 0;
        while (mru_answers.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en    = 1'b0;
        shadow_limit = v;
    endtask

    initial
    begin : rsp_stall_pattern
        int unsigned mode;
        int unsigned left;
        rsp_if.ready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(64, 400);
            while (left != 0)
            begin
                @(negedge clk);
                case (mode)
                    0: rsp_if.ready = 1'b1;
                    1: rsp_if.ready = ($urandom_range(0, 1) == 1);
                    2: rsp_if.ready = ((left % 8) >= 3);
                    default: rsp_if.ready = ($urandom_range(0, 15) == 0);
                endcase
                left--;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (mru_answers.size() == 0)
                flag("result with nothing expected", 0, 0);
            else
                check_answer(rsp_if.data, mru_answers.pop_front());
        end
    end

    initial
    begin : stimulus
        entry_t     ka;
        entry_t     kb;
        entry_t     kc;
        entry_t     k0;
        entry_t     k0p;
        entry_t     k1;
        entry_t     k1z;
        rsp_t       none;
        dir_row_t   row;
        logic [5:0] limits [8];

        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        req_if.valid  = 1'b0;
        req_if.data   = '0;
        shadow_count  = 0;
        shadow_limit  = MAX_ENTRIES_RESET;
        burst_left    = 0;
        mismatches    = 0;

        ka  = '{8'h01, 8'h02, 12'h003, 16'h0004, 10'h005};
        kb  = ka;
        kb.service_id = 16'h8000;
        kc  = ka;
        kc.driver_id = 8'h80;
        k0  = '0;
        k0p = '0;
        k0p.service_number = 10'h155;
        k1  = '1;
        k1z = '1;
        k1z.service_number = '0;
        none = bare_answer(1'b0, 5'd0, 1'b0, 6'd0);

        dir_rows.push_back(cfg_row(MAX_ENTRIES_RESET));
        dir_rows.push_back(fixed_row(FUNC_READ, 5'd0, k0, none));
        dir_rows.push_back(fixed_row(FUNC_NOP, 5'd31, k1, none));
        dir_rows.push_back(fixed_row(FUNC_READ, 5'd31, k0, none));
        dir_rows.push_back(fixed_row(FUNC_CLEAR, 5'd0, k0, none));
        dir_rows.push_back(fixed_row(FUNC_ADD, 5'd0, k0, bare_answer(1'b0, 5'd0, 1'b0, 6'd1)));
        dir_rows.push_back(item_row(FUNC_ADD, 5'd31, k1));
        dir_rows.push_back(item_row(FUNC_READ, 5'd0, k0));
        dir_rows.push_back(item_row(FUNC_READ, 5'd1, k0));
        // front hit keeps the stored payload
        dir_rows.push_back(fixed_row(FUNC_ADD, 5'd0, k1z, bare_answer(1'b1, 5'd0, 1'b0, 6'd2)));
        dir_rows.push_back(item_row(FUNC_READ, 5'd0, k0));
        dir_rows.push_back(item_row(FUNC_ADD, 5'd0, ka));
        dir_rows.push_back(item_row(FUNC_ADD, 5'd0, kb));
        dir_rows.push_back(item_row(FUNC_ADD, 5'd0, kc));
        dir_rows.push_back(item_row(FUNC_ADD, 5'd0, k0p));
        dir_rows.push_back(item_row(FUNC_READ, 5'd0, k0));
        dir_rows.push_back(item_row(FUNC_READ, 5'd4, k0));
        dir_rows.push_back(item_row(FUNC_READ, 5'd5, k0));
        dir_rows.push_back(fixed_row(FUNC_CLEAR, 5'd0, k0, none));
        dir_rows.push_back(fixed_row(FUNC_READ, 5'd0, k0, none));
        dir_rows.push_back(cfg_row(6'd0));
        dir_rows.push_back(fixed_row(FUNC_ADD, 5'd0, ka, bare_answer(1'b0, 5'd0, 1'b1, 6'd0)));
        dir_rows.push_back(cfg_row(6'd1));
        dir_rows.push_back(item_row(FUNC_ADD, 5'd0, ka));
        dir_rows.push_back(item_row(FUNC_ADD, 5'd0, kb));
        dir_rows.push_back(item_row(FUNC_READ, 5'd0, k0));
        dir_rows.push_back(cfg_row(6'd63));
        dir_rows.push_back(item_row(FUNC_ADD, 5'd0, kc));
        dir_rows.push_back(item_row(FUNC_READ, 5'd1, k0));
        dir_rows.push_back(item_row(FUNC_ADD, 5'd0, kb));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[k])
        begin
            row = dir_rows[k];
            if (row.cfg)
                write_limit(row.cfg_val);
            else
                send_item(row.r, row.fixed, row.want);
        end

        // full list, then limits dropped below the count without a clear
        limits = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd20, 6'd33, 6'd2, 6'd32};
        limits[6] = 6'($urandom_range(2, 31));
        foreach (limits[p])
        begin
            write_limit(limits[p]);
            refresh_key_pool();
            repeat (PHASE_ITEMS)
                send_item(next_random_req(), 1'b0, '0);
        end

        req_if.valid = 1'b0;
        while (mru_answers.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
